>>> sv/tsv_gradient_stencil_assert.svh
// Assertion macros shared by the stencil RTL.
`ifndef TSV_GRADIENT_STENCIL_ASSERT_SVH
`define TSV_GRADIENT_STENCIL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TSVG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tsvg_pkg.sv
`timescale 1ns / 1ps

package tsvg_pkg;

  localparam int PIX_W       = 16;
  localparam int GRAD_W      = 20;
  localparam int GSUM_W      = GRAD_W - 1;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 16;
  localparam int TOTAL_W     = 55;
  localparam int SQ_W        = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (GRAD_W + COL_W + ROW_W + TOTAL_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COL_W-1:0] WIDTH_RESET  = 6'd32;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // One unit of work for the datapath: either a pixel or one step of the
  // last-row flush.
  typedef struct packed {
    logic                     emit;
    logic                     pix;
    logic                     last;
    logic                     wrap;
    logic                     fwd;
    logic                     has_uu;
    logic                     has_left;
    logic                     has_right;
    logic                     has_down;
    logic                     var_left;
    logic                     var_up;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic signed [PIX_W-1:0]  down;
  } item_t;

  // Exact difference of two pixels, one bit wider than a pixel.
  function automatic logic signed [PIX_W:0] sdiff(input logic signed [PIX_W-1:0] a,
                                                  input logic signed [PIX_W-1:0] b);
    return {a[PIX_W-1], a} - {b[PIX_W-1], b};
  endfunction

endpackage

>>> sv/tsv_gradient_stencil.sv
// A gradient is formed once the pixel below its own pixel is taken; it then passes
// stage 1, stage 2 and the output register, any of which can stall. Throughput: one
// pixel per cycle unless stalled; an image's last pixel is followed by a flush step per column in use
// The row store is a three-row ring memory read on two ports; no clearing pass.
// Reset (synchronous rst) restores width and height to 32 and starts a new image.
`timescale 1ns / 1ps
`include "tsv_gradient_stencil_assert.svh"

module tsv_gradient_stencil
  import tsvg_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] pixel
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [19:0] gradient, [25:20] out_column, [41:26] out_row,
  // [96:42] total_variation, [103:97] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,   // last_of_image
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  // Configuration and image position.
  logic [COL_W-1:0] image_width;
  logic [ROW_W-1:0] image_height;
  logic [COL_W-1:0] weff, wlast;
  logic [ROW_W-1:0] heff, hlast;
  logic             wr_width, wr_height, cfg_hit;

  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [1:0]       rr, r1, r2;

  logic             flushing;
  logic [COL_W-1:0] fcol;
  logic [ROW_W-1:0] frow;
  logic [1:0]       fr0, fr1;

  // Issue stage.
  logic             pix_acc, fl_issue, issue;
  logic             pix_wrap, pix_last, fl_wrap;
  item_t            item;
  logic [AW-1:0]    addr_a, addr_b, waddr;
  logic signed [PIX_W-1:0] pix_in;

  // Row store.
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_a, rd_b;

  // Stage 1.
  logic             s1_v, s1_free, s1_adv;
  item_t            s1;
  logic signed [PIX_W-1:0] center, gleft, lpix;
  logic signed [PIX_W:0]   d_uu, d_l, d_r, d_d, dl, du;
  logic signed [GSUM_W-1:0] gsum;
  logic signed [2*PIX_W+1:0] pl, pu;

  // Stage 2.
  logic                s2_v, s2_free, s2_adv, s2_emit, s2_last;
  logic [GRAD_W-1:0]   s2_grad;
  logic [COL_W-1:0]    s2_col;
  logic [ROW_W-1:0]    s2_row;
  logic [SQ_W-1:0]     s2_sq_l, s2_sq_u;
  logic [TOTAL_W-1:0]  acc, acc_next;

  // Output register.
  logic                out_v, s3_free;
  logic [GRAD_W-1:0]   out_grad;
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    out_row;
  logic [TOTAL_W-1:0]  out_total;
  logic                out_last;

  function automatic logic [AW-1:0] ring_addr(input logic [1:0] ring,
                                              input logic [COL_W-1:0] col);
    return AW'(AW'(ring) * AW'(MAX_WIDTH)) + AW'(col);
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_comb begin
    wr_width  = 1'b0;
    wr_height = 1'b0;
    unique case (cfg_reg_t'(cfg_index))
      REG_IMAGE_WIDTH:  wr_width  = cfg_valid;
      REG_IMAGE_HEIGHT: wr_height = cfg_valid;
      default: ;
    endcase
  end

  assign cfg_hit = wr_width || wr_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else begin
      if (wr_width)  image_width  <= cfg_data[COL_W-1:0];
      if (wr_height) image_height <= cfg_data[ROW_W-1:0];
    end
  end

  always_comb begin
    if (image_width == '0) begin
      weff = COL_W'(1);
    end else if (image_width > COL_W'(MAX_WIDTH)) begin
      weff = COL_W'(MAX_WIDTH);
    end else begin
      weff = image_width;
    end
    heff  = (image_height == '0) ? ROW_W'(1) : image_height;
    wlast = weff - COL_W'(1);
    hlast = heff - ROW_W'(1);
  end

  // ----------------------------------------------------------------- issue
  assign s_tready = s1_free && !flushing;
  assign pix_acc  = s_tvalid && s_tready;
  assign fl_issue = flushing && s1_free;
  assign issue    = pix_acc || fl_issue;
  assign pix_in   = signed'(s_tdata[PIX_W-1:0]);

  always_comb begin
    r1       = (rr == 2'd0) ? 2'd2 : rr - 2'd1;
    r2       = (r1 == 2'd0) ? 2'd2 : r1 - 2'd1;
    pix_wrap = (col_cnt == wlast);
    pix_last = pix_wrap && (row_cnt == hlast);
    fl_wrap  = (fcol == wlast);
    waddr    = ring_addr(rr, col_cnt);
    item     = '0;
    if (flushing) begin
      // Last row: the right neighbor comes from port A, the row above from port B.
      item.emit      = 1'b1;
      item.last      = fl_wrap;
      item.has_uu    = (frow != '0);
      item.has_left  = (fcol != '0);
      item.has_right = !fl_wrap;
      item.col       = fcol;
      item.row       = frow;
      addr_a = fl_wrap ? ring_addr(fr0, '0) : ring_addr(fr0, fcol + COL_W'(1));
      addr_b = ring_addr(fr1, fcol);
    end else begin
      // The pixel completes the gradient of the pixel above it. At the end of a
      // row, port A fetches column zero of this row as the next center.
      item.emit      = (row_cnt != '0);
      item.pix       = 1'b1;
      item.wrap      = pix_wrap;
      item.fwd       = pix_wrap && (col_cnt == '0);
      item.has_uu    = (row_cnt > ROW_W'(1));
      item.has_left  = (col_cnt != '0);
      item.has_right = !pix_wrap;
      item.has_down  = 1'b1;
      item.var_left  = (col_cnt != '0);
      item.var_up    = (row_cnt != '0);
      item.col       = col_cnt;
      item.row       = row_cnt - ROW_W'(1);
      item.down      = pix_in;
      addr_a = pix_wrap ? ring_addr(rr, '0) : ring_addr(r1, col_cnt + COL_W'(1));
      addr_b = ring_addr(r2, col_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      rr       <= 2'd0;
      flushing <= 1'b0;
      fcol     <= '0;
      frow     <= '0;
      fr0      <= 2'd0;
      fr1      <= 2'd0;
    end else if (cfg_hit) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      rr       <= 2'd0;
      flushing <= 1'b0;
    end else if (pix_acc) begin
      if (pix_last) begin
        col_cnt  <= '0;
        row_cnt  <= '0;
        rr       <= 2'd0;
        flushing <= 1'b1;
        fcol     <= '0;
        frow     <= row_cnt;
        fr0      <= rr;
        fr1      <= r1;
      end else if (pix_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + ROW_W'(1);
        rr      <= (rr == 2'd2) ? 2'd0 : rr + 2'd1;
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end else if (fl_issue) begin
      if (fl_wrap) begin
        flushing <= 1'b0;
      end else begin
        fcol <= fcol + COL_W'(1);
      end
    end
  end

  // ------------------------------------------------------------- row store
  always_ff @(posedge clk) begin
    if (pix_acc) mem[waddr] <= s_tdata[PIX_W-1:0];
    if (issue) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // --------------------------------------------------------------- stage 1
  assign s3_free = !out_v || m_tready;
  assign s2_adv  = s2_v && (!s2_emit || s3_free);
  assign s2_free = !s2_v || s2_adv;
  assign s1_adv  = s1_v && s2_free;
  assign s1_free = !s1_v || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) s1 <= item;
  end

  always_comb begin
    d_uu = s1.has_uu    ? sdiff(center, signed'(rd_b)) : '0;
    d_l  = s1.has_left  ? sdiff(center, gleft)         : '0;
    d_r  = s1.has_right ? sdiff(center, signed'(rd_a)) : '0;
    d_d  = s1.has_down  ? sdiff(center, s1.down)       : '0;
    gsum = GSUM_W'(d_uu) + GSUM_W'(d_l) + GSUM_W'(d_r) + GSUM_W'(d_d);
    dl   = s1.var_left ? sdiff(lpix, s1.down)   : '0;
    du   = s1.var_up   ? sdiff(center, s1.down) : '0;
    pl   = (2*PIX_W+2)'(dl) * (2*PIX_W+2)'(dl);
    pu   = (2*PIX_W+2)'(du) * (2*PIX_W+2)'(du);
  end

  // The center and left window slides along the row being graded.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1.wrap) begin
        center <= s1.fwd ? s1.down : signed'(rd_a);
      end else begin
        gleft  <= center;
        center <= signed'(rd_a);
      end
      if (s1.pix) lpix <= s1.down;
    end
  end

  // --------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_emit <= s1.emit;
      s2_last <= s1.last;
      s2_grad <= {gsum, 1'b0};
      s2_col  <= s1.col;
      s2_row  <= s1.row;
      s2_sq_l <= pl[SQ_W-1:0];
      s2_sq_u <= pu[SQ_W-1:0];
    end
  end

  assign acc_next = acc + TOTAL_W'(s2_sq_l) + TOTAL_W'(s2_sq_u);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      acc <= '0;
    end else if (s2_adv) begin
      acc <= s2_last ? '0 : acc_next;
    end
  end

  // ------------------------------------------------------------ output reg
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s3_free) begin
      out_v <= s2_adv && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_emit) begin
      out_grad  <= s2_grad;
      out_col   <= s2_col;
      out_row   <= s2_row;
      out_total <= s2_last ? acc_next : '0;
      out_last  <= s2_last;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_total, out_row, out_col, out_grad};
  assign m_tlast  = out_last;

  // ------------------------------------------------------------ assertions
  `TSVG_ASSERT_SAME(a_col_in_range, clk, rst, 1'b1, col_cnt < weff, "column count beyond width")
  `TSVG_ASSERT_SAME(a_ring_in_range, clk, rst, 1'b1, rr != 2'd3, "row ring index out of range")
  `TSVG_ASSERT_SAME(a_flush_col, clk, rst, flushing, fcol < weff, "flush column beyond width")
  `TSVG_ASSERT_SAME(a_flush_blocks, clk, rst, flushing, !s_tready, "pixel taken during flush")
  `TSVG_ASSERT_NEXT(a_accept_loads, clk, rst, s_tvalid && s_tready, s1_v && s1.pix, "pixel lost")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import tsvg_pkg::*;
();

  localparam int MAX_W         = 32;
  localparam int COL_LSB       = GRAD_W;
  localparam int ROW_LSB       = COL_LSB + COL_W;
  localparam int TOT_LSB       = ROW_LSB + ROW_W;
  localparam int PAD_LSB       = TOT_LSB + TOTAL_W;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;

  // Index that decodes to no register; a write there must leave the image alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;
  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic [COL_W-1:0]         column;
    logic [ROW_W-1:0]         row;
    logic [TOTAL_W-1:0]       total;
    logic                     last;
  } gradient_beat_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bit idle_on           = 1'b1;
  int sink_hold_cycles  = 0;
  int mismatch_count    = 0;
  int pixels_sent       = 0;
  int images_done       = 0;
  int results_seen      = 0;

  // Image state mirrored on the testbench side.
  logic signed [PIX_W-1:0] ring_mem [3][MAX_W];
  logic [COL_W-1:0]        width_reg;
  logic [ROW_W-1:0]        height_reg;
  int                      next_col;
  int                      next_row;
  logic [TOTAL_W-1:0]      run_sum;
  logic signed [PIX_W-1:0] left_pix;
  gradient_beat_t          pending_gradients [$];

  always #5 clk = ~clk;

  tsv_gradient_stencil #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic void restart_image();
    next_col = 0;
    next_row = 0;
    run_sum  = '0;
    left_pix = '0;
  endfunction

  function automatic void reset_image_state();
    foreach (ring_mem[r, c]) ring_mem[r][c] = '0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_image();
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = d[COL_W-1:0];
      restart_image();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = d[ROW_W-1:0];
      restart_image();
    end
  endfunction

  function automatic int stored(input int r, input int c);
    return int'(ring_mem[r % 3][c]);
  endfunction

  function automatic longint sq_diff(input int a, input int b);
    longint d;
    d = longint'(a - b);
    return d * d;
  endfunction

  // Twice the sum of (pixel - neighbor) over the neighbors that exist.
  function automatic int neighbour_grad(input int r, input int c, input int w,
                                        input bit has_below, input int below);
    int ctr;
    int acc;
    ctr = stored(r, c);
    acc = 0;
    if (r >= 1) acc += ctr - stored(r - 1, c);
    if (c >= 1) acc += ctr - stored(r, c - 1);
    if (c + 1 < w) acc += ctr - stored(r, c + 1);
    if (has_below) acc += ctr - below;
    return 2 * acc;
  endfunction

  function automatic void push_gradient(input int g, input int c, input int r,
                                        input logic [TOTAL_W-1:0] total, input bit end_flag);
    gradient_beat_t b;
    b.gradient = g[GRAD_W-1:0];
    b.column   = c[COL_W-1:0];
    b.row      = r[ROW_W-1:0];
    b.total    = total;
    b.last     = end_flag;
    pending_gradients.push_back(b);
  endfunction

  function automatic void compute_gradients(input logic signed [PIX_W-1:0] pix);
    int w;
    int h;
    int c;
    int r;
    int pv;
    w  = active_width();
    h  = active_height();
    c  = next_col;
    r  = next_row;
    pv = int'(pix);
    if (c >= 1) run_sum += TOTAL_W'(sq_diff(int'(left_pix), pv));
    if (r >= 1) begin
      run_sum += TOTAL_W'(sq_diff(stored(r - 1, c), pv));
      push_gradient(neighbour_grad(r - 1, c, w, 1'b1, pv), c, r - 1, '0, 1'b0);
    end
    ring_mem[r % 3][c] = pix;
    left_pix = pix;
    if (c + 1 >= w && r + 1 >= h) begin
      // The last pixel flushes the whole bottom row; the total rides on its last beat.
      for (int k = 0; k < w; k++)
        push_gradient(neighbour_grad(r, k, w, 1'b0, 0), k, r,
                      (k + 1 == w) ? run_sum : '0, k + 1 == w);
      images_done++;
      restart_image();
    end else if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1) % 65536;
      left_pix = '0;
    end else begin
      next_col = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_beat();
    gradient_beat_t got;
    gradient_beat_t want;
    got.gradient = m_tdata[GRAD_W-1:0];
    got.column   = m_tdata[COL_LSB +: COL_W];
    got.row      = m_tdata[ROW_LSB +: ROW_W];
    got.total    = m_tdata[TOT_LSB +: TOTAL_W];
    got.last     = m_tlast;
    results_seen++;
    if (pending_gradients.size() == 0) begin
      report_mismatch($sformatf("unexpected beat for row %0d column %0d",
                                got.row, got.column));
      return;
    end
    want = pending_gradients.pop_front();
    if (got.gradient !== want.gradient)
      report_mismatch($sformatf("gradient row %0d col %0d: got %0d, want %0d",
                                want.row, want.column, $signed(got.gradient),
                                $signed(want.gradient)));
    if (got.column !== want.column)
      report_mismatch($sformatf("column: got %0d, want %0d", got.column, want.column));
    if (got.row !== want.row)
      report_mismatch($sformatf("row: got %0d, want %0d", got.row, want.row));
    if (got.total !== want.total)
      report_mismatch($sformatf("total row %0d col %0d: got %0d, want %0d",
                                want.row, want.column, got.total, want.total));
    if (got.last !== want.last)
      report_mismatch($sformatf("tlast row %0d col %0d: got %0b, want %0b",
                                want.row, want.column, got.last, want.last));
    if (m_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
      report_mismatch("padding bits of m_tdata not zero");
  endtask

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) check_beat();

  // Output side: random stalls, plus one long hold-off when a test asks for it.
  initial begin
    int hold;
    m_tready = 1'b0;
    forever begin
      if (sink_hold_cycles != 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
        m_tready <= 1'b0;
        for (int n = 0; n < hold; n++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic signed [PIX_W-1:0] any_pixel();
    int v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      2, 3:    v = $urandom_range(0, 31) - 16;
      default: ;
    endcase
    return v[PIX_W-1:0];
  endfunction

  task automatic send_pixel(input logic signed [PIX_W-1:0] pix);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    compute_gradients(pix);
    pixels_sent++;
  endtask

  // Lets every pending gradient come out, then gives the pipeline time to empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, d);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd);
    write_reg(REG_IMAGE_WIDTH, wd, 1'b1);
    write_reg(REG_IMAGE_HEIGHT, hd, 1'b0);
  endtask

  // Reset sizes are 32 by 32; one row and a bit is enough to see them in use.
  task automatic test_reset_sizes();
    repeat (36) send_pixel(any_pixel());
  endtask

  // Center pixel against four opposite extremes gives the largest gradients.
  task automatic test_extreme_pixels();
    wait_idle();
    set_size(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? PIX_MAX : PIX_MIN);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? PIX_MIN : PIX_MAX);
  endtask

  task automatic test_degenerate_sizes();
    wait_idle();
    // Width field zero with the upper data bits set, height zero: a 1x1 image.
    set_size(16'hFFC0, 16'h0000);
    send_pixel(PIX_MAX);
    wait_idle();
    set_size(16'd1, 16'd4);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel('0);
  endtask

  task automatic test_clamped_width();
    wait_idle();
    set_size(16'hFFFF, 16'd2);
    repeat (64) send_pixel(any_pixel());
  endtask

  // Tallest setting, left unfinished; the next size write must abandon it.
  task automatic test_tall_abandon();
    wait_idle();
    set_size(16'h0042, 16'hFFFF);
    repeat (20) send_pixel(any_pixel());
    wait_idle();
    write_reg(REG_SPARE, 16'hFFFF, 1'b0);
    repeat (6) send_pixel(any_pixel());
  endtask

  task automatic test_stall_fill();
    wait_idle();
    set_size(16'd8, 16'd6);
    sink_hold_cycles = LONG_HOLD;
    repeat (48) send_pixel(any_pixel());
  endtask

  task automatic test_random_images(input int quota);
    int sent;
    int n;
    logic [COL_W-1:0]            wsel;
    logic [CFG_DATA_W-COL_W-1:0] junk;
    logic [ROW_W-1:0]            hsel;
    sent = 0;
    while (sent < quota) begin
      case ($urandom_range(0, 9))
        0:       wsel = '0;
        1:       wsel = COL_W'($urandom_range(MAX_W + 1, 63));
        2, 3:    wsel = COL_W'($urandom_range(9, MAX_W));
        default: wsel = COL_W'($urandom_range(1, 8));
      endcase
      junk = (CFG_DATA_W - COL_W)'($urandom);
      hsel = ($urandom_range(0, 7) == 0) ? '0 :
             ROW_W'($urandom_range(1, (wsel > 8) ? 2 : 4));
      wait_idle();
      set_size({junk, wsel}, hsel);
      n = active_width() * active_height();
      // Some images stop partway and are dropped by the next size write.
      if (n > 1 && $urandom_range(0, 5) == 0) n = $urandom_range(1, n - 1);
      repeat (n) send_pixel(any_pixel());
      sent += n;
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    idle_on = 1'b0;
    set_size(16'd6, 16'd5);
    repeat (30) send_pixel(any_pixel());
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    reset_image_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_sizes();
    test_extreme_pixels();
    test_degenerate_sizes();
    test_clamped_width();
    test_tall_abandon();
    test_stall_fill();
    test_random_images(100);
    test_steady_stream();
    wait_idle();

    $display("%0d pixels sent, %0d images completed, %0d gradient beats checked",
             pixels_sent, images_done, results_seen);
    $display("sizes 1x1 up to clamped width, zero and tall settings, abandoned images, long stall");
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
